@@ rtl/cstp_pkg.sv @@
// ---------------------------------------------------------------------------
// cstp_pkg
// Shared types and codes for the call stack time profiler.
// ---------------------------------------------------------------------------
package cstp_pkg;

  localparam logic [1:0] REQ_ENTER = 2'd0;
  localparam logic [1:0] REQ_EXIT  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  thread_sel;
    logic [7:0]  region_id;
    logic [63:0] time_stamp;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] num_calls;
    logic [63:0] inclusive_total;
    logic [63:0] exclusive_total;
    logic [63:0] min_time;
    logic [63:0] max_time;
    logic [63:0] avg_time;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item, start memory reads
    logic clr_step;  // write one clearing row
    logic rd_stat;   // read stack top, then addressed and caller statistic rows
    logic update;    // compute and write back
    logic div_start;
  } cstp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic div_busy;
  } cstp_sts_t;

endpackage

@@ rtl/call_stack_time_profiler_top.sv @@
// ---------------------------------------------------------------------------
// call_stack_time_profiler_top
// Per-thread call stack profiler with region statistics.
// ---------------------------------------------------------------------------
// in channel: in_valid / in_stall with in_item (enter, exit or read event).
// out channel: out_valid / out_stall with out_item, one result per item.
// After reset the statistics memory is swept, one row a cycle, over all
// NUM_THREADS*NUM_REGIONS rows (1024 by default); in_stall stays high.
// out_valid rises after the stack and statistics memory read-modify-write
// (stack top read, statistic row read, write back) and the average: a
// start, 64 one-bit divider steps and a finish.
// One item is in flight at a time; in_stall is high until the result has
// been taken. When the receiver stalls, out_item holds steady and the
// block waits.
// ---------------------------------------------------------------------------
module call_stack_time_profiler_top #(
  parameter int NUM_THREADS = 4,
  parameter int NUM_REGIONS = 256,
  parameter int STACK_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cstp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output cstp_pkg::out_item_t out_item
);
  import cstp_pkg::*;

  cstp_cmd_t cmd;
  cstp_sts_t sts;

  cstp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cstp_datapath #(
    .NUM_THREADS (NUM_THREADS),
    .NUM_REGIONS (NUM_REGIONS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

@@ rtl/cstp_div.sv @@
// ---------------------------------------------------------------------------
// cstp_div
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor.
// ---------------------------------------------------------------------------
module cstp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [6:0]  count;
  logic [63:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem[31:0], quo[63]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= 7'd64;
    end else if (count != 7'd0) begin
      count <= count - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (count != 7'd0) begin
      if (!diff[32]) begin
        rem <= diff;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign busy     = (count != 7'd0);
  // zero count yields zero average
  assign quotient = (dvs == 32'd0) ? 64'd0 : quo;

endmodule

@@ rtl/cstp_datapath.sv @@
// ---------------------------------------------------------------------------
// cstp_datapath
// Stack, resume time and statistics memories with update arithmetic.
// ---------------------------------------------------------------------------
module cstp_datapath #(
  parameter int NUM_THREADS = 4,
  parameter int NUM_REGIONS = 256,
  parameter int STACK_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cstp_pkg::cstp_cmd_t  cmd,
  output cstp_pkg::cstp_sts_t  sts,
  input  cstp_pkg::in_item_t   in_item,
  output cstp_pkg::out_item_t  out_item
);
  import cstp_pkg::*;

  localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int RW = $clog2(NUM_REGIONS);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int SE = NUM_THREADS * NUM_REGIONS;
  localparam int SW = $clog2(SE);
  localparam int FE = NUM_THREADS * STACK_DEPTH;
  localparam int FW = $clog2(FE);

  typedef struct packed {
    logic [31:0] cnt;
    logic [63:0] incl;
    logic [63:0] excl;
    logic [63:0] mn;
    logic [63:0] mx;
  } stat_t;

  stat_t       stat_mem [SE];
  logic [RW-1:0] frm_reg_mem [FE];
  logic [63:0] frm_time_mem [FE];
  logic [LW-1:0] level [NUM_THREADS];
  logic [63:0] resume [NUM_THREADS];

  logic [1:0]    req;
  logic [TW-1:0] thr;
  logic [RW-1:0] reg_id;
  logic [63:0]   ts;
  logic [LW-1:0] lvl;
  logic [63:0]   res_t;
  logic [RW-1:0] top_reg;
  logic [63:0]   top_time;
  stat_t         s_rd;
  stat_t         c_rd;
  stat_t         s_res;
  logic [1:0]    status;
  logic [SW:0]   clr_addr;
  logic [TW-1:0] thr_in;
  logic [FW-1:0] top_addr;

  logic [SW-1:0] s_addr;
  logic [SW-1:0] c_addr;
  logic [FW-1:0] push_addr;
  logic          is_enter;
  logic          is_exit;
  logic          full;
  logic          match;
  logic          has_caller;
  logic [63:0]   incl;
  logic [63:0]   excl_d;
  stat_t         s_new;
  stat_t         c_new;
  logic          div_busy;
  logic [63:0]   quotient;

  // remainder of a small index by a fixed count, eight shift-subtract steps
  function automatic logic [15:0] mod_small(input logic [7:0] v, input int unsigned n);
    logic [16:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[15:0], v[i]};
      if (32'(r) >= n) r = r - 17'(n);
    end
    mod_small = r[15:0];
  endfunction

  assign thr_in = TW'(mod_small(8'(in_item.thread_sel), NUM_THREADS));

  function automatic logic [FW-1:0] faddr(input logic [TW-1:0] t, input logic [LW-1:0] l);
    faddr = FW'(32'(t) * STACK_DEPTH + 32'(l));
  endfunction

  // stage one: capture item, form stack top address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req      <= in_item.req_type;
      thr      <= thr_in;
      reg_id   <= RW'(mod_small(in_item.region_id, NUM_REGIONS));
      ts       <= in_item.time_stamp;
      lvl      <= level[thr_in];
      res_t    <= resume[thr_in];
      top_addr <= faddr(thr_in, level[thr_in] - LW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_stat) begin
      top_reg  <= frm_reg_mem[top_addr];
      top_time <= frm_time_mem[top_addr];
    end
  end

  assign s_addr    = SW'(32'(thr) * NUM_REGIONS + 32'(reg_id));
  assign c_addr    = SW'(32'(thr) * NUM_REGIONS + 32'(top_reg));
  assign push_addr = faddr(thr, lvl);
  assign is_enter  = (req == REQ_ENTER);
  assign is_exit   = (req == REQ_EXIT);
  assign full      = (32'(lvl) >= STACK_DEPTH);
  assign has_caller = (lvl != '0);
  assign match     = has_caller && (top_reg == reg_id);

  // statistic rows read in the cycle after the stack top
  logic rd_phase;
  always_ff @(posedge clk) begin
    if (rst) rd_phase <= 1'b0;
    else     rd_phase <= cmd.rd_stat;
  end

  always_ff @(posedge clk) begin
    if (rd_phase) begin
      s_rd <= stat_mem[s_addr];
      c_rd <= stat_mem[c_addr];
    end
  end

  assign incl   = ts - top_time;
  assign excl_d = ts - res_t;

  always_comb begin
    s_new = s_rd;
    c_new = c_rd;
    c_new.excl = c_rd.excl + excl_d;
    if (s_rd.cnt != 32'hFFFF_FFFF) s_new.cnt = s_rd.cnt + 32'd1;
    s_new.incl = s_rd.incl + incl;
    if (incl < s_rd.mn) s_new.mn = incl;
    if (incl > s_rd.mx) s_new.mx = incl;
    s_new.excl = s_rd.excl + excl_d;
  end

  // clear sweep and write back share the single write port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      stat_mem[clr_addr[SW-1:0]] <= '{cnt: '0, incl: '0, excl: '0, mn: '1, mx: '0};
    end else if (cmd.update) begin
      if (is_enter && !full && has_caller)
        stat_mem[c_addr] <= c_new;
      else if (is_exit && match)
        stat_mem[s_addr] <= s_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && is_enter && !full) begin
      frm_reg_mem[push_addr]  <= reg_id;
      frm_time_mem[push_addr] <= ts;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + (SW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_THREADS; i++) begin
        level[i]  <= '0;
        resume[i] <= '0;
      end
    end else if (cmd.update) begin
      if (is_enter && !full) begin
        level[thr]  <= lvl + LW'(1);
        resume[thr] <= ts;
      end else if (is_exit && match) begin
        level[thr]  <= lvl - LW'(1);
        resume[thr] <= ts;
      end
    end
  end

  // result row as it stands after the request
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (is_enter) begin
        status <= full ? ST_OVERFLOW : ST_OK;
        s_res  <= (!full && has_caller && c_addr == s_addr) ? c_new : s_rd;
      end else if (is_exit) begin
        status <= match ? ST_OK : ST_MISMATCH;
        s_res  <= match ? s_new : s_rd;
      end else begin
        status <= ST_OK;
        s_res  <= s_rd;
      end
    end
  end

  cstp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (s_res.incl),
    .divisor  (s_res.cnt),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign sts.clr_done = (clr_addr == (SW+1)'(SE - 1)) && cmd.clr_step;
  assign sts.div_busy = div_busy;

  assign out_item.status          = status;
  assign out_item.num_calls       = s_res.cnt;
  assign out_item.inclusive_total = s_res.incl;
  assign out_item.exclusive_total = s_res.excl;
  assign out_item.min_time        = s_res.mn;
  assign out_item.max_time        = s_res.mx;
  assign out_item.avg_time        = quotient;

`ifndef SYNTH
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> 32'(lvl) <= STACK_DEPTH)
    else $error("stack level beyond depth");
  a_no_clr_update: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_step && cmd.update))
    else $error("clear and update together");
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    cmd.update && is_exit && match |=> s_res.mn <= s_res.mx)
    else $error("min above max after exit");
`endif

endmodule

@@ rtl/cstp_ctrl.sv @@
// ---------------------------------------------------------------------------
// cstp_ctrl
// Sequencer: clearing sweep, memory read phases, divide and output handshake.
// ---------------------------------------------------------------------------
module cstp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  cstp_pkg::cstp_sts_t sts,
  output cstp_pkg::cstp_cmd_t cmd
);
  import cstp_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_TOP   = 7'b0000100,
    S_STAT  = 7'b0001000,
    S_UPD   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   div_go;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) div_go <= 1'b0;
    else     div_go <= (state == S_UPD);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clr_done) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_TOP;
      S_TOP:   state_next = S_STAT;
      S_STAT:  state_next = S_UPD;
      S_UPD:   state_next = S_DIV;
      S_DIV:   if (!div_go && !sts.div_busy) state_next = S_OUT;
      S_OUT:   if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall      = (state != S_IDLE);
  assign out_valid     = (state == S_OUT);
  assign cmd.load      = (state == S_IDLE) && in_valid;
  assign cmd.clr_step  = (state == S_CLEAR);
  assign cmd.rd_stat   = (state == S_TOP);
  assign cmd.update    = (state == S_UPD);
  assign cmd.div_start = div_go;

`ifndef SYNTH
  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !out_valid)
    else $error("accept while result pending");
  a_div_after_upd: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> cmd.div_start)
    else $error("divide not started");
`endif

endmodule
